/* design/mnp_pkg.sv */
// Shared constants, types and helpers for the MIDI note event pairer.
package mnp_pkg;

    // Table geometry and tick counter size
    localparam int NUM_CHANNELS = 16;
    localparam int NUM_KEYS     = 128;
    localparam int TICK_WIDTH   = 32;

    // Fixed field widths
    localparam int CMD_W      = 3;
    localparam int DELTA_W    = 28;
    localparam int CH_W       = 4;
    localparam int KEY_W      = 7;
    localparam int VEL_W      = 7;
    localparam int PROG_W     = 7;
    localparam int TEMPO_W    = 24;
    localparam int OUT_TICK_W = 32;

    // Table addressing
    localparam int CH_AW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int KEY_AW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int TBL_DEPTH = NUM_CHANNELS * NUM_KEYS;
    localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    // Tick adder width, with room for the carry
    localparam int SUM_W = ((TICK_WIDTH > DELTA_W) ? TICK_WIDTH : DELTA_W) + 1;

    // Result queue sizing; the count also holds depth plus one result in flight
    localparam int FIFO_DEPTH = 3;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 2);

    localparam logic [TEMPO_W-1:0] TEMPO_DEFAULT = TEMPO_W'(500000);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_NOTE_ON   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_NOTE_OFF  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PROGRAM   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TEMPO     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TRACK_END = 3'd4;

    // Result kinds
    localparam logic KIND_NOTE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Table update ops issued from the lookup stage
    typedef enum logic [1:0] {
        TBL_NONE,
        TBL_SET,
        TBL_CLEAR,
        TBL_CLEAR_ALL
    } tbl_op_t;

    // Work for the lookup stage
    typedef enum logic [1:0] {
        S1_NONE,
        S1_NOTE_ON,
        S1_NOTE_OFF,
        S1_SUMMARY
    } s1_op_t;

    // One open-note entry
    typedef struct packed {
        logic [OUT_TICK_W-1:0] start;
        logic [VEL_W-1:0]      vel;
    } tbl_entry_t;

    // Update request to the table
    typedef struct packed {
        tbl_op_t    op;
        tbl_entry_t entry;
    } tbl_upd_t;

    // Lookup answer from the table
    typedef struct packed {
        logic       hit;
        tbl_entry_t entry;
    } tbl_hit_t;

    // Table address of a channel and key
    function automatic logic [TBL_AW-1:0] tbl_addr(input logic [CH_W-1:0] ch,
                                                   input logic [KEY_W-1:0] key);
        return TBL_AW'(int'(ch) * NUM_KEYS + int'(key));
    endfunction

endpackage

/* design/mnp_table.sv */
// Open-note table: valid-row RAM, entry RAM, row live flags and write forwarding.
module mnp_table import mnp_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [CH_W-1:0]  rd_channel,
    input  logic [KEY_W-1:0] rd_key,
    input  tbl_upd_t         upd,
    output tbl_hit_t         look
);

    // One row of valid bits per channel, one entry per channel and key
    logic [NUM_KEYS-1:0] row_mem [NUM_CHANNELS];
    tbl_entry_t          data_mem [TBL_DEPTH];

    logic [NUM_CHANNELS-1:0] row_live_reg, row_live_next;
    logic [NUM_KEYS-1:0]     row_q_reg;
    tbl_entry_t              data_q_reg;
    logic [CH_AW-1:0]        ch_reg;
    logic [KEY_AW-1:0]       key_reg;
    logic [TBL_AW-1:0]       addr_reg;

    logic                    fw_row_en_reg, fw_row_en_next;
    logic [CH_AW-1:0]        fw_ch_reg;
    logic [NUM_KEYS-1:0]     fw_row_reg;
    logic                    fw_data_en_reg, fw_data_en_next;
    logic [TBL_AW-1:0]       fw_addr_reg;
    tbl_entry_t              fw_data_reg;

    logic [CH_AW-1:0]        rd_ch_a;
    logic [KEY_AW-1:0]       rd_key_a;
    logic [TBL_AW-1:0]       rd_addr;
    logic [NUM_KEYS-1:0]     row_cur, row_new;
    tbl_entry_t              data_cur;
    logic                    row_we, data_we;

    assign rd_ch_a  = CH_AW'(rd_channel);
    assign rd_key_a = KEY_AW'(rd_key);
    assign rd_addr  = tbl_addr(rd_channel, rd_key);

    // Current row and entry: last beat's write wins over the RAM read
    always_comb
    begin
        if (fw_row_en_reg && (fw_ch_reg == ch_reg))
        begin
            row_cur = fw_row_reg;
        end
        else if (row_live_reg[ch_reg])
        begin
            row_cur = row_q_reg;
        end
        else
        begin
            row_cur = '0;
        end
        if (fw_data_en_reg && (fw_addr_reg == addr_reg))
        begin
            data_cur = fw_data_reg;
        end
        else
        begin
            data_cur = data_q_reg;
        end
    end

    assign look.hit   = row_cur[key_reg];
    assign look.entry = data_cur;

    // Modify
    always_comb
    begin
        row_new       = row_cur;
        row_we        = 1'b0;
        data_we       = 1'b0;
        row_live_next = row_live_reg;
        unique case (upd.op)
            TBL_SET:
            begin
                row_new[key_reg]      = 1'b1;
                row_we                = 1'b1;
                data_we               = 1'b1;
                row_live_next[ch_reg] = 1'b1;
            end
            TBL_CLEAR:
            begin
                row_new[key_reg]      = 1'b0;
                row_we                = 1'b1;
                row_live_next[ch_reg] = 1'b1;
            end
            TBL_CLEAR_ALL:
            begin
                row_live_next = '0;
            end
            TBL_NONE:
            begin
            end
            default:
            begin
            end
        endcase
        fw_row_en_next  = row_we;
        fw_data_en_next = data_we;
    end

    // RAM ports: read at accept, write back in the following cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            row_q_reg  <= row_mem[rd_ch_a];
            data_q_reg <= data_mem[rd_addr];
            ch_reg     <= rd_ch_a;
            key_reg    <= rd_key_a;
            addr_reg   <= rd_addr;
        end
        if (row_we)
        begin
            row_mem[ch_reg] <= row_new;
        end
        if (data_we)
        begin
            data_mem[addr_reg] <= upd.entry;
        end
    end

    // Forwarding payload
    always_ff @(posedge clk)
    begin
        fw_ch_reg   <= ch_reg;
        fw_row_reg  <= row_new;
        fw_addr_reg <= addr_reg;
        fw_data_reg <= upd.entry;
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_live_reg   <= '0;
            fw_row_en_reg  <= 1'b0;
            fw_data_en_reg <= 1'b0;
        end
        else
        begin
            row_live_reg   <= row_live_next;
            fw_row_en_reg  <= fw_row_en_next;
            fw_data_en_reg <= fw_data_en_next;
        end
    end

endmodule

/* design/midi_note_event_pairer.sv */
// MIDI note event pairer: tick counter, track state, lookup stage and result queue.
// A result passes through the lookup stage register and then the result queue before it is shown.
// Throughput: one input beat per cycle while the result queue has room; the open-note RAMs are read at accept and
// written back the next cycle, with one-beat forwarding covering back-to-back hits.
// A 3-entry result queue holds results while the output side stalls.
// Reset is asynchronous; no clearing pass: per-channel row flags mark the table empty
// at once, and a track end drops them all together.
module midi_note_event_pairer import mnp_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CMD_W-1:0]      command,
    input  logic [DELTA_W-1:0]    delta_ticks,
    input  logic [CH_W-1:0]       midi_channel,
    input  logic [KEY_W-1:0]      note_key,
    input  logic [VEL_W-1:0]      note_velocity,
    input  logic [PROG_W-1:0]     program_number,
    input  logic [TEMPO_W-1:0]    tempo_value,
    input  logic                  tempo_length_ok,
    input  logic                  is_first_track,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  result_kind,
    output logic [KEY_W-1:0]      out_key,
    output logic [CH_W-1:0]       out_channel,
    output logic [OUT_TICK_W-1:0] start_tick,
    output logic [OUT_TICK_W-1:0] length_ticks,
    output logic [VEL_W-1:0]      out_velocity,
    output logic [PROG_W-1:0]     track_instrument,
    output logic                  channel_known,
    output logic [CH_W-1:0]       first_channel,
    output logic [TEMPO_W-1:0]    current_tempo
);

    typedef struct packed {
        logic                  kind;
        logic [KEY_W-1:0]      key;
        logic [CH_W-1:0]       ch;
        logic [OUT_TICK_W-1:0] start;
        logic [OUT_TICK_W-1:0] length;
        logic [VEL_W-1:0]      vel;
        logic [PROG_W-1:0]     instr;
        logic                  known;
        logic [CH_W-1:0]       first_ch;
        logic [TEMPO_W-1:0]    tempo;
    } out_rec_t;

    // Track state
    logic                  any_track_reg;
    logic [TICK_WIDTH-1:0] tick_reg, tick_next;
    logic [PROG_W-1:0]     prog_reg, prog_next;
    logic                  seen_reg, seen_next;
    logic [CH_W-1:0]       first_ch_reg, first_ch_next;
    logic [TEMPO_W-1:0]    tempo_reg, tempo_next;

    // Lookup stage
    logic                  s1_valid_reg;
    s1_op_t                s1_op_reg, s0_op;
    logic [KEY_W-1:0]      s1_key_reg;
    logic [CH_W-1:0]       s1_ch_reg;
    logic [VEL_W-1:0]      s1_vel_reg;
    logic [OUT_TICK_W-1:0] s1_tick_reg;
    logic [PROG_W-1:0]     s1_instr_reg;
    logic                  s1_known_reg;
    logic [CH_W-1:0]       s1_first_reg;
    logic [TEMPO_W-1:0]    s1_tempo_reg;

    // Result queue
    out_rec_t              fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    logic                  accept, in_table, is_on, is_off, touch_channel;
    logic [SUM_W-1:0]      tick_sum;
    logic [TICK_WIDTH-1:0] tick_sat;
    logic                  s1_may_push, push, pop;
    out_rec_t              push_rec, head_rec;
    tbl_upd_t              upd;
    tbl_hit_t              look;

    assign accept   = in_valid && in_ready;
    assign in_table = (int'(midi_channel) < NUM_CHANNELS) && (int'(note_key) < NUM_KEYS);
    assign is_on    = (command == CMD_NOTE_ON) && (note_velocity != '0);
    assign is_off   = ((command == CMD_NOTE_ON) && (note_velocity == '0))
                   || (command == CMD_NOTE_OFF);

    // Saturating tick add
    assign tick_sum = SUM_W'(tick_reg) + SUM_W'(delta_ticks);
    assign tick_sat = (|tick_sum[SUM_W-1:TICK_WIDTH]) ? '1 : tick_sum[TICK_WIDTH-1:0];

    // Accept stage: classify the beat
    always_comb
    begin
        priority if (is_on && in_table)
        begin
            s0_op = S1_NOTE_ON;
        end
        else if (is_off && in_table)
        begin
            s0_op = S1_NOTE_OFF;
        end
        else if (command == CMD_TRACK_END)
        begin
            s0_op = S1_SUMMARY;
        end
        else
        begin
            s0_op = S1_NONE;
        end
    end

    assign touch_channel = is_on || (command == CMD_PROGRAM);

    // Accept stage: track state update
    always_comb
    begin
        tick_next     = tick_reg;
        prog_next     = prog_reg;
        seen_next     = seen_reg;
        first_ch_next = first_ch_reg;
        tempo_next    = tempo_reg;
        if (accept)
        begin
            tick_next = tick_sat;
            if (touch_channel && !seen_reg)
            begin
                seen_next     = 1'b1;
                first_ch_next = midi_channel;
            end
            if (command == CMD_PROGRAM)
            begin
                prog_next = program_number;
            end
            if ((command == CMD_TEMPO) && tempo_length_ok
                && (is_first_track || any_track_reg))
            begin
                tempo_next = tempo_value;
            end
            if (command == CMD_TRACK_END)
            begin
                tick_next     = '0;
                prog_next     = '0;
                seen_next     = 1'b0;
                first_ch_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_track_reg <= 1'b0;
            tick_reg      <= '0;
            prog_reg      <= '0;
            seen_reg      <= 1'b0;
            first_ch_reg  <= '0;
            tempo_reg     <= TEMPO_DEFAULT;
            s1_valid_reg  <= 1'b0;
            s1_op_reg     <= S1_NONE;
        end
        else
        begin
            if (cfg_we)
            begin
                any_track_reg <= cfg_wdata;
            end
            tick_reg     <= tick_next;
            prog_reg     <= prog_next;
            seen_reg     <= seen_next;
            first_ch_reg <= first_ch_next;
            tempo_reg    <= tempo_next;
            s1_valid_reg <= accept;
            s1_op_reg    <= accept ? s0_op : S1_NONE;
        end
    end

    // Lookup stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_key_reg   <= note_key;
            s1_ch_reg    <= midi_channel;
            s1_vel_reg   <= note_velocity;
            s1_tick_reg  <= OUT_TICK_W'(tick_sat);
            s1_instr_reg <= prog_reg;
            s1_known_reg <= seen_reg;
            s1_first_reg <= first_ch_reg;
            s1_tempo_reg <= tempo_reg;
        end
    end

    mnp_table u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (accept && ((s0_op == S1_NOTE_ON) || (s0_op == S1_NOTE_OFF))),
        .rd_channel (midi_channel),
        .rd_key     (note_key),
        .upd        (upd),
        .look       (look)
    );

    // Lookup stage: table update and result build
    always_comb
    begin
        upd.op          = TBL_NONE;
        upd.entry.start = s1_tick_reg;
        upd.entry.vel   = s1_vel_reg;
        push            = 1'b0;
        push_rec        = '0;
        unique case (s1_op_reg)
            S1_NOTE_ON:
            begin
                upd.op = TBL_SET;
            end
            S1_NOTE_OFF:
            begin
                if (look.hit)
                begin
                    upd.op          = TBL_CLEAR;
                    push            = 1'b1;
                    push_rec.kind   = KIND_NOTE;
                    push_rec.key    = s1_key_reg;
                    push_rec.ch     = s1_ch_reg;
                    push_rec.start  = look.entry.start;
                    push_rec.length = s1_tick_reg - look.entry.start;
                    push_rec.vel    = look.entry.vel;
                end
            end
            S1_SUMMARY:
            begin
                upd.op            = TBL_CLEAR_ALL;
                push              = 1'b1;
                push_rec.kind     = KIND_SUMMARY;
                push_rec.instr    = s1_instr_reg;
                push_rec.known    = s1_known_reg;
                push_rec.first_ch = s1_first_reg;
                push_rec.tempo    = s1_tempo_reg;
            end
            S1_NONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Result queue: admit a beat only if room remains for every result in flight
    assign s1_may_push = s1_valid_reg
                      && ((s1_op_reg == S1_NOTE_OFF) || (s1_op_reg == S1_SUMMARY));
    assign in_ready    = (cnt_reg + CNT_W'(s1_may_push)) < CNT_W'(FIFO_DEPTH);
    assign out_valid   = (cnt_reg != '0);
    assign pop         = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
        end
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_rec;
        end
    end

    // Output beat
    assign head_rec         = fifo_mem[rd_ptr_reg];
    assign result_kind      = head_rec.kind;
    assign out_key          = head_rec.key;
    assign out_channel      = head_rec.ch;
    assign start_tick       = head_rec.start;
    assign length_ticks     = head_rec.length;
    assign out_velocity     = head_rec.vel;
    assign track_instrument = head_rec.instr;
    assign channel_known    = head_rec.known;
    assign first_channel    = head_rec.first_ch;
    assign current_tempo    = head_rec.tempo;

    // Queue never overflows
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg < CNT_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

    // Count stays within depth
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

    // Track end restarts the tick counter
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (command == CMD_TRACK_END)) |=> (tick_reg == '0))
        else $error("tick counter not cleared by track end");

    // A track end always yields a summary in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (command == CMD_TRACK_END)) |=> (push && (push_rec.kind == KIND_SUMMARY)))
        else $error("track end without summary");

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the MIDI note event pairer: directed and track-shaped random beats.
module tb_top import mnp_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // Command codes with no name in the package; all only advance time
    localparam logic [CMD_W-1:0] CMD_OTHER  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    localparam int STALL_LIMIT = 2000;

    // One input beat
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [DELTA_W-1:0] delta;
        logic [CH_W-1:0]    ch;
        logic [KEY_W-1:0]   key;
        logic [VEL_W-1:0]   vel;
        logic [PROG_W-1:0]  prog;
        logic [TEMPO_W-1:0] tempo;
        logic               tempo_ok;
        logic               first_track;
    } midi_event_t;

    // One output beat: note record or track summary
    typedef struct packed {
        logic                  kind;
        logic [KEY_W-1:0]      key;
        logic [CH_W-1:0]       ch;
        logic [OUT_TICK_W-1:0] start;
        logic [OUT_TICK_W-1:0] len;
        logic [VEL_W-1:0]      vel;
        logic [PROG_W-1:0]     instr;
        logic                  known;
        logic [CH_W-1:0]       first_ch;
        logic [TEMPO_W-1:0]    tempo;
    } note_rec_t;

    // Note pairing predictor and queue of records still to come out
    class note_pair_board;
        note_rec_t             records_due[$];
        bit                    any_track;
        logic [TICK_WIDTH-1:0] tick_now;
        bit                    open_flag[TBL_DEPTH];
        logic [TICK_WIDTH-1:0] open_tick[TBL_DEPTH];
        logic [VEL_W-1:0]      open_vel[TBL_DEPTH];
        logic [PROG_W-1:0]     last_prog;
        bit                    ch_seen;
        logic [CH_W-1:0]       ch_first;
        logic [TEMPO_W-1:0]    tempo_held;
        int unsigned           fails;
        int unsigned           note_count;
        int unsigned           summary_count;
        int unsigned           saturate_count;

        function new();
            any_track  = 1'b0;
            tick_now   = '0;
            last_prog  = '0;
            ch_seen    = 1'b0;
            ch_first   = '0;
            tempo_held = TEMPO_DEFAULT;
            foreach (open_flag[i]) open_flag[i] = 1'b0;
        endfunction

        function int pending();
            return records_due.size();
        endfunction

        function void mark_channel(logic [CH_W-1:0] ch);
            if (!ch_seen) begin
                ch_seen  = 1'b1;
                ch_first = ch;
            end
        endfunction

        // Advance time, apply the beat, queue the record it produces
        function void note_event(midi_event_t ev);
            logic [TICK_WIDTH:0] sum;
            int                  slot;
            note_rec_t           rec;
            sum  = tick_now + ev.delta;
            slot = int'(ev.ch) * NUM_KEYS + int'(ev.key);
            rec  = '0;
            if (sum > {1'b0, {TICK_WIDTH{1'b1}}}) begin
                tick_now = '1;
                saturate_count++;
            end
            else
                tick_now = sum[TICK_WIDTH-1:0];

            case (ev.cmd)
                CMD_NOTE_ON, CMD_NOTE_OFF:
                begin
                    if (ev.cmd == CMD_NOTE_ON && ev.vel != 0) begin
                        // start or retrigger
                        mark_channel(ev.ch);
                        open_flag[slot] = 1'b1;
                        open_tick[slot] = tick_now;
                        open_vel[slot]  = ev.vel;
                    end
                    else if (open_flag[slot]) begin
                        open_flag[slot] = 1'b0;
                        rec.kind  = KIND_NOTE;
                        rec.key   = ev.key;
                        rec.ch    = ev.ch;
                        rec.start = OUT_TICK_W'(open_tick[slot]);
                        rec.len   = OUT_TICK_W'(tick_now - open_tick[slot]);
                        rec.vel   = open_vel[slot];
                        records_due = {records_due, rec};
                        note_count++;
                    end
                end
                CMD_PROGRAM:
                begin
                    last_prog = ev.prog;
                    mark_channel(ev.ch);
                end
                CMD_TEMPO:
                begin
                    if (ev.tempo_ok && (ev.first_track || any_track))
                        tempo_held = ev.tempo;
                end
                CMD_TRACK_END:
                begin
                    rec.kind     = KIND_SUMMARY;
                    rec.instr    = last_prog;
                    rec.known    = ch_seen;
                    rec.first_ch = ch_first;
                    rec.tempo    = tempo_held;
                    records_due  = {records_due, rec};
                    summary_count++;
                    // per-track state starts over; tempo survives
                    tick_now  = '0;
                    last_prog = '0;
                    ch_seen   = 1'b0;
                    ch_first  = '0;
                    foreach (open_flag[i]) open_flag[i] = 1'b0;
                end
                default: ;
            endcase
        endfunction

        function void compare(string what, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
                fails++;
            end
        endfunction

        // Check one output beat against the oldest queued record
        function void check_result(note_rec_t got);
            note_rec_t want;
            if (records_due.size() == 0) begin
                $display("%0t: output beat with nothing expected, expected none actual kind %0d",
                         $time, got.kind);
                fails++;
                return;
            end
            want = records_due.pop_front();
            compare("result_kind", want.kind, got.kind);
            compare("out_key", want.key, got.key);
            compare("out_channel", want.ch, got.ch);
            compare("start_tick", want.start, got.start);
            compare("length_ticks", want.len, got.len);
            compare("out_velocity", want.vel, got.vel);
            compare("track_instrument", want.instr, got.instr);
            compare("channel_known", want.known, got.known);
            compare("first_channel", want.first_ch, got.first_ch);
            compare("current_tempo", want.tempo, got.tempo);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_wdata;
    logic                  in_valid;
    logic                  in_ready;
    logic [CMD_W-1:0]      command;
    logic [DELTA_W-1:0]    delta_ticks;
    logic [CH_W-1:0]       midi_channel;
    logic [KEY_W-1:0]      note_key;
    logic [VEL_W-1:0]      note_velocity;
    logic [PROG_W-1:0]     program_number;
    logic [TEMPO_W-1:0]    tempo_value;
    logic                  tempo_length_ok;
    logic                  is_first_track;
    logic                  out_valid;
    logic                  out_ready;
    logic                  result_kind;
    logic [KEY_W-1:0]      out_key;
    logic [CH_W-1:0]       out_channel;
    logic [OUT_TICK_W-1:0] start_tick;
    logic [OUT_TICK_W-1:0] length_ticks;
    logic [VEL_W-1:0]      out_velocity;
    logic [PROG_W-1:0]     track_instrument;
    logic                  channel_known;
    logic [CH_W-1:0]       first_channel;
    logic [TEMPO_W-1:0]    current_tempo;

    note_pair_board board;
    bit             send_gaps;
    bit             sink_stalls;
    int unsigned    beats_in;
    int unsigned    cfg_writes;
    int unsigned    idle_cycles;

    midi_note_event_pairer i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .delta_ticks      (delta_ticks),
        .midi_channel     (midi_channel),
        .note_key         (note_key),
        .note_velocity    (note_velocity),
        .program_number   (program_number),
        .tempo_value      (tempo_value),
        .tempo_length_ok  (tempo_length_ok),
        .is_first_track   (is_first_track),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result_kind      (result_kind),
        .out_key          (out_key),
        .out_channel      (out_channel),
        .start_tick       (start_tick),
        .length_ticks     (length_ticks),
        .out_velocity     (out_velocity),
        .track_instrument (track_instrument),
        .channel_known    (channel_known),
        .first_channel    (first_channel),
        .current_tempo    (current_tempo)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Output side: ready with random stall bursts
    initial
    begin
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (sink_stalls && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // Output monitor
    always @(posedge clk)
    begin
        note_rec_t got;
        if (rst_n && out_valid && out_ready) begin
            got.kind     = result_kind;
            got.key      = out_key;
            got.ch       = out_channel;
            got.start    = start_tick;
            got.len      = length_ticks;
            got.vel      = out_velocity;
            got.instr    = track_instrument;
            got.known    = channel_known;
            got.first_ch = first_channel;
            got.tempo    = current_tempo;
            board.check_result(got);
        end
    end

    // Watchdog: too long without any beat on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic midi_event_t make_event(logic [CMD_W-1:0] cmd, logic [DELTA_W-1:0] delta,
                                               logic [CH_W-1:0] ch, logic [KEY_W-1:0] key,
                                               logic [VEL_W-1:0] vel, logic [PROG_W-1:0] prog,
                                               logic [TEMPO_W-1:0] tempo, logic ok, logic first);
        midi_event_t ev;
        ev.cmd         = cmd;
        ev.delta       = delta;
        ev.ch          = ch;
        ev.key         = key;
        ev.vel         = vel;
        ev.prog        = prog;
        ev.tempo       = tempo;
        ev.tempo_ok    = ok;
        ev.first_track = first;
        return ev;
    endfunction

    // Fully random beat, every field at full width
    function automatic midi_event_t noise_event();
        return make_event(CMD_W'($urandom), DELTA_W'($urandom), CH_W'($urandom),
                          KEY_W'($urandom), VEL_W'($urandom), PROG_W'($urandom),
                          TEMPO_W'($urandom), 1'($urandom), 1'($urandom));
    endfunction

    // Present one beat, with an optional gap in front; called and returns at a clock edge
    task automatic drive_event(input midi_event_t ev);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        command         <= ev.cmd;
        delta_ticks     <= ev.delta;
        midi_channel    <= ev.ch;
        note_key        <= ev.key;
        note_velocity   <= ev.vel;
        program_number  <= ev.prog;
        tempo_value     <= ev.tempo;
        tempo_length_ok <= ev.tempo_ok;
        is_first_track  <= ev.first_track;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_event(ev);
        beats_in++;
    endtask

    // Hold off input until every queued record is out, then let the pipe settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_any_track(input bit val);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.any_track = val;
        cfg_writes++;
    endtask

    // One track: notes around a small key/channel pool, then a track end
    task automatic play_track(input int n_items, input bit first_trk);
        midi_event_t     ev;
        logic [CH_W-1:0]  base_ch;
        logic [KEY_W-1:0] base_key;
        int               mode;
        int               pick;
        base_ch  = CH_W'($urandom);
        base_key = KEY_W'($urandom);
        mode     = $urandom_range(0, 9);
        for (int i = 0; i < n_items; i++) begin
            ev = noise_event();
            if ($urandom_range(0, 19) != 0) begin
                ev.first_track = ($urandom_range(0, 19) == 0) ? !first_trk : first_trk;
                // delta profile chosen per track; the last one drives the counter to its cap
                if (mode < 5)
                    ev.delta = DELTA_W'($urandom_range(0, 7));
                else if (mode < 8)
                    ev.delta = DELTA_W'($urandom_range(0, 5000));
                else if (mode == 9 && $urandom_range(0, 3) != 0)
                    ev.delta = '1;
                if ($urandom_range(0, 6) != 0) begin
                    ev.ch  = base_ch ^ CH_W'($urandom_range(0, 1));
                    ev.key = base_key + KEY_W'($urandom_range(0, 7));
                end
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    ev.cmd = CMD_NOTE_ON;
                    ev.vel = VEL_W'($urandom_range(1, 127));
                end
                else if (pick < 58)
                    ev.cmd = CMD_NOTE_OFF;
                else if (pick < 64) begin
                    ev.cmd = CMD_NOTE_ON;
                    ev.vel = '0;
                end
                else if (pick < 71)
                    ev.cmd = CMD_PROGRAM;
                else if (pick < 79) begin
                    ev.cmd      = CMD_TEMPO;
                    ev.tempo_ok = ($urandom_range(0, 7) != 0);
                end
                else if (pick < 98)
                    ev.cmd = CMD_W'($urandom_range(CMD_OTHER, CMD_SPARE7));
                else
                    ev.cmd = CMD_TRACK_END;
            end
            drive_event(ev);
        end
        ev             = noise_event();
        ev.cmd         = CMD_TRACK_END;
        ev.first_track = first_trk;
        drive_event(ev);
    endtask

    task automatic run_tracks(input int unsigned target);
        int unsigned track_no;
        track_no = 0;
        while (beats_in < target) begin
            play_track($urandom_range(4, 48), (track_no % 3) == 0);
            track_no++;
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
    endtask

    // Main sequence
    initial
    begin
        board           = new();
        send_gaps       = 1'b1;
        sink_stalls     = 1'b1;
        beats_in        = 0;
        cfg_writes      = 0;
        idle_cycles     = 0;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= 1'b0;
        in_valid        <= 1'b0;
        command         <= CMD_OTHER;
        delta_ticks     <= '0;
        midi_channel    <= '0;
        note_key        <= '0;
        note_velocity   <= '0;
        program_number  <= '0;
        tempo_value     <= '0;
        tempo_length_ok <= 1'b0;
        is_first_track  <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_any_track(1'b0);

        // Directed: field extremes, retrigger, zero-velocity off, unmatched off, tempo rules
        drive_event(make_event(CMD_PROGRAM, '1, 4'd15, 7'd0, 7'd0, 7'd127, '0, 1'b0, 1'b1));
        drive_event(make_event(CMD_NOTE_ON, '0, 4'd0, 7'd0, 7'd127, 7'd0, '0, 1'b0, 1'b1));
        drive_event(make_event(CMD_NOTE_ON, 28'd1, 4'd15, 7'd127, 7'd1, 7'd0, '0, 1'b0, 1'b1));
        drive_event(make_event(CMD_NOTE_ON, 28'd5, 4'd0, 7'd0, 7'd64, 7'd0, '0, 1'b0, 1'b1));
        drive_event(make_event(CMD_NOTE_OFF, 28'd9, 4'd0, 7'd0, 7'd33, 7'd0, '0, 1'b0, 1'b1));
        drive_event(make_event(CMD_NOTE_ON, '1, 4'd15, 7'd127, 7'd0, 7'd0, '0, 1'b0, 1'b1));
        drive_event(make_event(CMD_NOTE_OFF, 28'd2, 4'd3, 7'd9, 7'd0, 7'd0, '0, 1'b0, 1'b1));
        drive_event(make_event(CMD_TEMPO, '0, 4'd0, 7'd0, 7'd0, 7'd0, '1, 1'b1, 1'b1));
        drive_event(make_event(CMD_TEMPO, '0, 4'd0, 7'd0, 7'd0, 7'd0, '0, 1'b0, 1'b1));
        drive_event(make_event(CMD_TEMPO, '0, 4'd0, 7'd0, 7'd0, 7'd0, '0, 1'b1, 1'b0));
        drive_event(make_event(CMD_OTHER, '1, 4'd5, 7'd5, 7'd5, 7'd5, '1, 1'b1, 1'b1));
        drive_event(make_event(CMD_SPARE6, '1, 4'd6, 7'd6, 7'd6, 7'd6, '1, 1'b1, 1'b1));
        drive_event(make_event(CMD_SPARE7, '1, 4'd7, 7'd7, 7'd7, 7'd7, '1, 1'b1, 1'b1));
        drive_event(make_event(CMD_NOTE_ON, 28'd3, 4'd7, 7'd64, 7'd100, 7'd0, '0, 1'b0, 1'b1));
        drive_event(make_event(CMD_TRACK_END, 28'd4, 4'd0, 7'd0, 7'd0, 7'd0, '0, 1'b0, 1'b1));
        // empty track, then an off for a note the track end dropped
        drive_event(make_event(CMD_TRACK_END, '0, 4'd0, 7'd0, 7'd0, 7'd0, '0, 1'b0, 1'b1));
        drive_event(make_event(CMD_NOTE_OFF, 28'd1, 4'd7, 7'd64, 7'd0, 7'd0, '0, 1'b0, 1'b0));
        drive_event(make_event(CMD_TEMPO, '0, 4'd0, 7'd0, 7'd0, 7'd0, '0, 1'b1, 1'b1));
        drive_event(make_event(CMD_TRACK_END, '0, 4'd0, 7'd0, 7'd0, 7'd0, '0, 1'b0, 1'b0));
        wait_drained();

        // Later-track tempo is taken once the register is set
        write_any_track(1'b1);
        drive_event(make_event(CMD_TEMPO, 28'd1, 4'd0, 7'd0, 7'd0, 7'd0, 24'd12345, 1'b1, 1'b0));
        drive_event(make_event(CMD_TRACK_END, '0, 4'd0, 7'd0, 7'd0, 7'd0, '0, 1'b0, 1'b0));
        wait_drained();

        // Random tracks under both register settings
        run_tracks(480);
        wait_drained();
        write_any_track(1'b0);
        run_tracks(920);
        wait_drained();
        write_any_track(1'b1);

        // Closing stretch at full rate
        send_gaps   = 1'b0;
        sink_stalls = 1'b0;
        run_tracks(1370);
        wait_drained();
        repeat (4) @(posedge clk);

        $display("Run covered %0d input beats, %0d paired notes, %0d track summaries,",
                 beats_in, board.note_count, board.summary_count);
        $display("%0d saturated tick sums and %0d register writes; %0d mismatches.",
                 board.saturate_count, cfg_writes, board.fails);
        if (board.fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
design/mnp_pkg.sv
design/mnp_table.sv
design/midi_note_event_pairer.sv
test/tb_top.sv
